[hdl/nq_pkg.sv]
// ----------------------------------------------------------------------------
// N-queens search package
// Shared constants, payload types, controller states and datapath commands.
// ----------------------------------------------------------------------------
package nq_pkg;

	localparam int MAX_BOARD_DEF = 16;
	localparam int BOARD_RESET   = 8;
	localparam int BSZ_W         = 5;
	localparam int ROW_W         = 4;
	localparam int COL_W         = 4;

	typedef struct packed {
		logic restart;
	} nq_in_t;

	typedef struct packed {
		logic [ROW_W-1:0] row_index;
		logic [COL_W-1:0] queen_column;
		logic             last_of_solution;
		logic             exhausted;
	} nq_out_t;

	typedef struct packed {
		logic [BSZ_W-1:0] board_size;
	} nq_cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT,
		ST_EXHAUST
	} nq_state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_INIT,
		OP_POP,
		OP_TRY,
		OP_EMIT_ROW,
		OP_EMIT_EXH
	} nq_op_t;

	typedef struct packed {
		logic started;
		logic at_solution;
		logic col_done;
		logic row_zero;
		logic cand_free;
		logic last_row;
		logic emit_last;
		logic out_free;
	} nq_status_t;

endpackage

[hdl/nq_chan_if.sv]
// ----------------------------------------------------------------------------
// Valid/ready channel
// Generic handshake channel carrying one payload item of type T.
// ----------------------------------------------------------------------------
interface nq_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/nq_ctrl.sv]
// ----------------------------------------------------------------------------
// N-queens controller
// State machine that sequences search, solution readout and exhaustion.
// ----------------------------------------------------------------------------
module nq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_restart,
	output logic               req_ready,
	input  nq_pkg::nq_status_t status,
	output nq_pkg::nq_op_t     op,
	output nq_pkg::nq_state_t  state
);

	nq_pkg::nq_state_t state_q;
	nq_pkg::nq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		op        = nq_pkg::OP_NONE;
		req_ready = 1'b0;
		unique case (state_q)
			nq_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_restart || !status.started) begin
						op      = nq_pkg::OP_INIT;
						state_d = nq_pkg::ST_SEARCH;
					end else if (status.at_solution) begin
						op      = nq_pkg::OP_POP;
						state_d = nq_pkg::ST_SEARCH;
					end else begin
						state_d = nq_pkg::ST_EXHAUST;
					end
				end
			end
			nq_pkg::ST_SEARCH: begin
				if (status.col_done) begin
					if (status.row_zero) begin
						state_d = nq_pkg::ST_EXHAUST;
					end else begin
						op = nq_pkg::OP_POP;
					end
				end else begin
					op = nq_pkg::OP_TRY;
					if (status.cand_free && status.last_row) begin
						state_d = nq_pkg::ST_EMIT;
					end
				end
			end
			nq_pkg::ST_EMIT: begin
				if (status.out_free) begin
					op = nq_pkg::OP_EMIT_ROW;
					if (status.emit_last) begin
						state_d = nq_pkg::ST_IDLE;
					end
				end
			end
			nq_pkg::ST_EXHAUST: begin
				if (status.out_free) begin
					op      = nq_pkg::OP_EMIT_EXH;
					state_d = nq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nq_pkg::ST_IDLE;
			end
		endcase
	end

	assign state = state_q;

endmodule

[hdl/nq_datapath.sv]
// ----------------------------------------------------------------------------
// N-queens datapath
// Occupancy masks, column stack, row and column counters, output register.
// ----------------------------------------------------------------------------
module nq_datapath #(
	parameter int MAX_BOARD = nq_pkg::MAX_BOARD_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  nq_pkg::nq_op_t           op,
	output nq_pkg::nq_status_t       status,
	input  logic                     cfg_we,
	input  logic [nq_pkg::BSZ_W-1:0] cfg_size,
	output logic                     out_valid,
	input  logic                     out_ready,
	output nq_pkg::nq_out_t          out_item
);

	localparam int CW      = $clog2(MAX_BOARD + 1);
	localparam int SW      = $clog2(MAX_BOARD);
	localparam int DW      = 2 * MAX_BOARD - 1;
	localparam int DIW     = $clog2(DW);
	localparam int N_RESET = (nq_pkg::BOARD_RESET > MAX_BOARD) ? MAX_BOARD
		: nq_pkg::BOARD_RESET;

	logic [CW-1:0]        n_q;
	logic [CW-1:0]        r_q;
	logic [CW-1:0]        c_q;
	logic [SW-1:0]        k_q;
	logic                 started_q;
	logic [MAX_BOARD-1:0] colf_q;
	logic [DW-1:0]        risef_q;
	logic [DW-1:0]        fallf_q;
	logic [SW-1:0]        stack_q [MAX_BOARD];
	logic                 out_valid_q;
	nq_pkg::nq_out_t      out_q;

	logic [CW-1:0]        n_eff;
	logic [CW-1:0]        r_dec;
	logic [CW-1:0]        n_dec;
	logic [SW-1:0]        rd_addr;
	logic [SW-1:0]        rd_col;
	logic [CW:0]          cand_rise;
	logic [CW:0]          cand_fall;
	logic [CW:0]          pop_rise;
	logic [CW:0]          pop_fall;
	logic [MAX_BOARD-1:0] cand_col_hot;
	logic [DW-1:0]        cand_rise_hot;
	logic [DW-1:0]        cand_fall_hot;
	logic [MAX_BOARD-1:0] pop_col_hot;
	logic [DW-1:0]        pop_rise_hot;
	logic [DW-1:0]        pop_fall_hot;
	logic                 cand_ok;
	logic                 out_free;

	// Board size zero counts as one; sizes above the maximum saturate.
	always_comb begin
		if (cfg_size == '0) begin
			n_eff = CW'(1);
		end else if (cfg_size > nq_pkg::BSZ_W'(MAX_BOARD)) begin
			n_eff = CW'(MAX_BOARD);
		end else begin
			n_eff = CW'(cfg_size);
		end
	end

	assign r_dec   = r_q - CW'(1);
	assign n_dec   = n_q - CW'(1);
	assign rd_addr = (op == nq_pkg::OP_EMIT_ROW) ? k_q : r_dec[SW-1:0];
	assign rd_col  = stack_q[rd_addr];

	// Rising diagonal index is row - col + N - 1, falling is row + col.
	assign cand_rise = {1'b0, r_q} + {1'b0, n_dec} - {1'b0, c_q};
	assign cand_fall = {1'b0, r_q} + {1'b0, c_q};
	assign pop_rise  = {1'b0, r_dec} + {1'b0, n_dec} - (CW + 1)'(rd_col);
	assign pop_fall  = {1'b0, r_dec} + (CW + 1)'(rd_col);

	assign cand_col_hot  = {{(MAX_BOARD - 1){1'b0}}, 1'b1} << c_q[SW-1:0];
	assign cand_rise_hot = {{(DW - 1){1'b0}}, 1'b1} << cand_rise[DIW-1:0];
	assign cand_fall_hot = {{(DW - 1){1'b0}}, 1'b1} << cand_fall[DIW-1:0];
	assign pop_col_hot   = {{(MAX_BOARD - 1){1'b0}}, 1'b1} << rd_col;
	assign pop_rise_hot  = {{(DW - 1){1'b0}}, 1'b1} << pop_rise[DIW-1:0];
	assign pop_fall_hot  = {{(DW - 1){1'b0}}, 1'b1} << pop_fall[DIW-1:0];

	assign cand_ok = (c_q < n_q) && ((colf_q & cand_col_hot) != '0)
		&& ((risef_q & cand_rise_hot) != '0) && ((fallf_q & cand_fall_hot) != '0);

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		status             = '0;
		status.started     = started_q;
		status.at_solution = (r_q == n_q);
		status.col_done    = (c_q >= n_q);
		status.row_zero    = (r_q == '0);
		status.cand_free   = cand_ok;
		status.last_row    = (r_q == n_dec);
		status.emit_last   = (CW'(k_q) == n_dec);
		status.out_free    = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= CW'(N_RESET);
			r_q         <= '0;
			c_q         <= '0;
			k_q         <= '0;
			started_q   <= 1'b0;
			colf_q      <= '1;
			risef_q     <= '1;
			fallf_q     <= '1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				n_q       <= n_eff;
				r_q       <= '0;
				started_q <= 1'b0;
				colf_q    <= '1;
				risef_q   <= '1;
				fallf_q   <= '1;
			end
			unique case (op)
				nq_pkg::OP_INIT: begin
					r_q       <= '0;
					c_q       <= '0;
					started_q <= 1'b1;
					colf_q    <= '1;
					risef_q   <= '1;
					fallf_q   <= '1;
				end
				nq_pkg::OP_POP: begin
					r_q     <= r_dec;
					c_q     <= CW'(rd_col) + CW'(1);
					colf_q  <= colf_q ^ pop_col_hot;
					risef_q <= risef_q ^ pop_rise_hot;
					fallf_q <= fallf_q ^ pop_fall_hot;
				end
				nq_pkg::OP_TRY: begin
					if (cand_ok) begin
						r_q     <= r_q + CW'(1);
						c_q     <= '0;
						k_q     <= '0;
						colf_q  <= colf_q ^ cand_col_hot;
						risef_q <= risef_q ^ cand_rise_hot;
						fallf_q <= fallf_q ^ cand_fall_hot;
					end else begin
						c_q <= c_q + CW'(1);
					end
				end
				nq_pkg::OP_EMIT_ROW: begin
					k_q <= k_q + SW'(1);
				end
				default: begin
				end
			endcase
			if (op == nq_pkg::OP_EMIT_ROW || op == nq_pkg::OP_EMIT_EXH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Column stack and result payload carry no reset.
	always_ff @(posedge clk) begin
		if (op == nq_pkg::OP_TRY && cand_ok) begin
			stack_q[r_q[SW-1:0]] <= c_q[SW-1:0];
		end
		if (op == nq_pkg::OP_EMIT_ROW) begin
			out_q.row_index        <= nq_pkg::ROW_W'(k_q);
			out_q.queen_column     <= nq_pkg::COL_W'(rd_col);
			out_q.last_of_solution <= (CW'(k_q) == n_dec);
			out_q.exhausted        <= 1'b0;
		end else if (op == nq_pkg::OP_EMIT_EXH) begin
			out_q.row_index        <= '0;
			out_q.queen_column     <= '0;
			out_q.last_of_solution <= 1'b1;
			out_q.exhausted        <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[hdl/n_queens_backtrack_search.sv]
// ----------------------------------------------------------------------------
// N-queens backtracking search
// Finds the next placement of N non-attacking queens on each request.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload                                      Handshake
//   req      in         restart                                      valid/ready
//   rsp      out        row_index, queen_column, last_of_solution,   valid/ready
//                       exhausted
//   cfg      in         board_size                                   valid/ready
//
// A request is taken while the block is idle, then the search tries one
// candidate column per cycle and backtracks one row at a time, so the time
// to the next solution follows the shape of the search tree. A solution is
// then read out one row per cycle while the result side keeps taking rows,
// and an exhausted result is a single item. The result register lets the
// block take the next request while the final result of the previous one
// still waits; a stalled result holds the readout. Reset sets the board size
// to eight and abandons any search in progress.
//
module n_queens_backtrack_search #(
	parameter int MAX_BOARD = nq_pkg::MAX_BOARD_DEF
) (
	input logic      clk,
	input logic      arst_n,
	nq_chan_if.sink   req,
	nq_chan_if.source rsp,
	nq_chan_if.sink   cfg
);

	nq_pkg::nq_status_t status;
	nq_pkg::nq_op_t     op;
	nq_pkg::nq_state_t  state;

	// Configuration writes are always taken; the user must write only when idle.
	assign cfg.ready = 1'b1;

	// The controller decides one command per cycle from the datapath status.
	nq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_restart (req.data.restart),
		.req_ready   (req.ready),
		.status      (status),
		.op          (op),
		.state       (state)
	);

	// The datapath holds the masks, the column stack and the result register.
	nq_datapath #(
		.MAX_BOARD (MAX_BOARD)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.status    (status),
		.cfg_we    (cfg.valid),
		.cfg_size  (cfg.data.board_size),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_item  (rsp.data)
	);

`ifndef SYNTHESIS
	// A queen is only placed on a column inside the board.
	a_try_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		op == nq_pkg::OP_TRY |-> !status.col_done)
		else $error("try issued past the last column");

	// Backtracking never pops below the first row.
	a_pop_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		op == nq_pkg::OP_POP |-> !status.row_zero)
		else $error("backtrack issued at row zero");

	// An exhausted result always carries zero fields and closes the item.
	a_exh_fields: assert property (@(posedge clk) disable iff (!arst_n)
		$past(op) == nq_pkg::OP_EMIT_EXH |-> rsp.valid && rsp.data.exhausted
			&& rsp.data.last_of_solution && rsp.data.row_index == '0
			&& rsp.data.queen_column == '0)
		else $error("malformed exhausted result");

	// Results are only loaded in the emit and exhaust states, never in idle or search.
	a_emit_state: assert property (@(posedge clk) disable iff (!arst_n)
		(op == nq_pkg::OP_EMIT_ROW || op == nq_pkg::OP_EMIT_EXH)
			|-> state != nq_pkg::ST_IDLE && state != nq_pkg::ST_SEARCH)
		else $error("result loaded outside readout");
`endif

endmodule

[tb/sv/tb_n_queens_backtrack_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// N-queens backtracking search testbench
// Drives search requests and board size writes over valid/ready channels with
// random gaps and stalls, predicts row results with an in-bench search of its
// own or takes typed-in rows, and checks each result item field by field in order.
// ----------------------------------------------------------------------------
module tb_n_queens_backtrack_search;

	localparam int          MAX_BOARD    = nq_pkg::MAX_BOARD_DEF;
	localparam int unsigned RANDOM_ITEMS = 152;
	// A sixteen-wide board needs a long search to its first placement, and
	// two of those are in the directed part, so this is loose.
	localparam longint      CYCLE_LIMIT  = 8_000_000;
	localparam int          SETTLE_CYCLES = 40;

	// Known placements, one nibble per row with row zero in the low nibble.
	localparam bit [63:0] EIGHT_FIRST = 64'h3162_5740;
	localparam bit [63:0] FOUR_FIRST  = 64'h2031;
	localparam bit [63:0] FOUR_SECOND = 64'h1302;

	typedef enum bit {
		STEP_WRITE_SIZE,
		STEP_REQUEST
	} step_kind_t;

	// One line of the directed plan. For a request, value bit 0 is restart.
	// A nonzero row count or the exhausted flag means the results are typed
	// in here instead of taken from the predictor.
	typedef struct {
		step_kind_t  kind;
		bit [4:0]    value;
		int unsigned typed_rows;
		bit          typed_exhausted;
		bit [63:0]   typed_columns;
	} step_t;

	logic clk;
	logic arst_n;

	nq_chan_if #(.T(nq_pkg::nq_in_t))  req_if ();
	nq_chan_if #(.T(nq_pkg::nq_out_t)) rsp_if ();
	nq_chan_if #(.T(nq_pkg::nq_cfg_t)) cfg_if ();

	n_queens_backtrack_search #(
		.MAX_BOARD(MAX_BOARD)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	// Shadow copy of the search state, kept in step with the block.
	bit [4:0]  shadow_board_size;
	bit [15:0] column_free;
	bit [30:0] rising_free;
	bit [30:0] falling_free;
	bit [3:0]  placed_column [16];
	bit [4:0]  search_depth;
	bit        search_live;

	nq_pkg::nq_out_t fresh_rows [$];
	nq_pkg::nq_out_t expected_rows [$];
	step_t           stimulus_plan [$];

	bit          steady;
	int unsigned ready_hold = 0;
	longint      cycle_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned requests_sent;
	int unsigned directed_requests;
	int unsigned size_writes;
	int unsigned solutions_seen = 0;
	int unsigned exhausted_seen = 0;

	// The clock toggles every half period; 10 ns period.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Gap lengths: mostly none or short, now and then a long one. A steady
	// phase turns all gaps off on both sides.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Board size zero acts as one, anything above the maximum saturates.
	function automatic int unsigned effective_size();
		int unsigned n;
		n = shadow_board_size;
		if (n == 0)
			n = 1;
		if (n > MAX_BOARD)
			n = MAX_BOARD;
		return n;
	endfunction

	function automatic void clear_masks();
		column_free  = '1;
		rising_free  = '1;
		falling_free = '1;
		search_depth = '0;
	endfunction

	// Places or lifts the queen at (r, c); rising diagonals are indexed
	// r - c + n - 1, falling diagonals r + c.
	function automatic void flip_queen(int unsigned r, int unsigned c, int unsigned n);
		column_free[c]          = ~column_free[c];
		rising_free[r + n - 1 - c] = ~rising_free[r + n - 1 - c];
		falling_free[r + c]     = ~falling_free[r + c];
	endfunction

	function automatic void push_exhausted_row();
		nq_pkg::nq_out_t row;
		row = '0;
		row.last_of_solution = 1'b1;
		row.exhausted = 1'b1;
		fresh_rows.insert(fresh_rows.size(), row);
	endfunction

	// Runs the depth-first search from where the last request left it and
	// leaves the rows of the next placement, or one exhausted row, in
	// fresh_rows. Columns are tried in increasing order, row by row.
	function automatic void solve_next_placement(bit restart);
		int unsigned     n;
		int unsigned     r;
		int unsigned     c;
		int unsigned     first_try;
		bit              placed;
		nq_pkg::nq_out_t row;
		n = effective_size();
		if (restart || !search_live) begin
			clear_masks();
			search_live = 1'b1;
			r = 0;
			first_try = 0;
		end else if (search_depth != n) begin
			// The previous request ran out of placements; say so again.
			push_exhausted_row();
			return;
		end else begin
			// Lift the last queen of the previous placement and move it on.
			r = n - 1;
			c = placed_column[r];
			flip_queen(r, c, n);
			first_try = c + 1;
		end
		while (1) begin
			placed = 1'b0;
			for (c = first_try; c < n; c++) begin
				if (column_free[c] && rising_free[r + n - 1 - c] && falling_free[r + c]) begin
					placed_column[r] = 4'(c);
					flip_queen(r, c, n);
					r++;
					placed = 1'b1;
					break;
				end
			end
			if (placed) begin
				if (r == n) begin
					search_depth = 5'(n);
					for (int unsigned k = 0; k < n; k++) begin
						row.row_index        = nq_pkg::ROW_W'(k);
						row.queen_column     = placed_column[k];
						row.last_of_solution = (k + 1 == n);
						row.exhausted        = 1'b0;
						fresh_rows.insert(fresh_rows.size(), row);
					end
					return;
				end
				first_try = 0;
			end else begin
				if (r == 0) begin
					search_depth = '0;
					push_exhausted_row();
					return;
				end
				r--;
				c = placed_column[r];
				flip_queen(r, c, n);
				first_try = c + 1;
			end
		end
	endfunction

	function automatic void add_step(step_kind_t kind, bit [4:0] value,
			int unsigned rows = 0, bit exh = 1'b0, bit [63:0] columns = '0);
		step_t s;
		s.kind            = kind;
		s.value           = value;
		s.typed_rows      = rows;
		s.typed_exhausted = exh;
		s.typed_columns   = columns;
		stimulus_plan.insert(stimulus_plan.size(), s);
	endfunction

	// Called at the edge where a request item is taken. The predictor always
	// runs so that its state follows the block; typed rows, where given,
	// replace what it predicts.
	function automatic void record_request(step_t s);
		nq_pkg::nq_out_t row;
		fresh_rows.delete();
		solve_next_placement(s.value[0]);
		requests_sent++;
		if (s.typed_exhausted) begin
			row = '0;
			row.last_of_solution = 1'b1;
			row.exhausted = 1'b1;
			expected_rows.insert(expected_rows.size(), row);
		end else if (s.typed_rows != 0) begin
			for (int unsigned k = 0; k < s.typed_rows; k++) begin
				row.row_index        = nq_pkg::ROW_W'(k);
				row.queen_column     = s.typed_columns[4*k +: 4];
				row.last_of_solution = (k + 1 == s.typed_rows);
				row.exhausted        = 1'b0;
				expected_rows.insert(expected_rows.size(), row);
			end
		end else begin
			foreach (fresh_rows[i])
				expected_rows.insert(expected_rows.size(), fresh_rows[i]);
		end
	endfunction

	// Each task below starts by waiting for a falling edge, where inputs
	// change. A request task returns at the rising edge that took the item,
	// so the next task decides at the following falling edge whether valid
	// stays high or drops; valid is never lowered and raised in one step.
	task automatic send_request(input step_t s);
		int unsigned    gap;
		nq_pkg::nq_in_t payload;
		gap = pick_gap();
		payload.restart = s.value[0];
		@(negedge clk);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.data  <= payload;
		req_if.valid <= 1'b1;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		record_request(s);
	endtask

	// Holds the request side idle until every expected row has come back.
	task automatic drain_results();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (expected_rows.size() != 0)
			@(posedge clk);
	endtask

	// The register is only written once the block has delivered everything.
	task automatic write_board_size(input bit [4:0] size);
		nq_pkg::nq_cfg_t payload;
		payload.board_size = size;
		drain_results();
		@(negedge clk);
		cfg_if.data  <= payload;
		cfg_if.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		// A write abandons whatever search was in progress.
		shadow_board_size = size;
		clear_masks();
		search_live = 1'b0;
		size_writes++;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic run_step(input step_t s);
		if (s.kind == STEP_WRITE_SIZE)
			write_board_size(s.value);
		else
			send_request(s);
	endtask

	// Result side: random backpressure, changed at the falling edge.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else if (ready_hold > 0) begin
			ready_hold--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= 1'b1;
			ready_hold = pick_gap();
		end
	end

	function automatic void report_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatch_count++;
		end
	endfunction

	// Every result item taken at a rising edge is matched against the
	// oldest expectation.
	always @(posedge clk) begin
		nq_pkg::nq_out_t want;
		nq_pkg::nq_out_t got;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.data;
			if (expected_rows.size() == 0) begin
				$error("%s row %0d column %0d last %0b exh %0b",
					"result item with nothing expected:",
					got.row_index, got.queen_column, got.last_of_solution, got.exhausted);
				mismatch_count++;
			end else begin
				want = expected_rows.pop_front();
				report_field("row_index", want.row_index, got.row_index);
				report_field("queen_column", want.queen_column, got.queen_column);
				report_field("last_of_solution", want.last_of_solution, got.last_of_solution);
				report_field("exhausted", want.exhausted, got.exhausted);
				if (want.exhausted)
					exhausted_seen++;
				else if (want.last_of_solution)
					solutions_seen++;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d rows still expected",
				cycle_count, expected_rows.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int unsigned random_items;
		int unsigned phase_len;
		int unsigned roll;
		bit [4:0]    size;
		step_t       s;

		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data  = '0;
		steady       = 1'b0;
		requests_sent  = 0;
		size_writes    = 0;
		random_items   = 0;

		// Reset state of the shadow: eight by eight board, no search yet.
		shadow_board_size = 5'(nq_pkg::BOARD_RESET);
		clear_masks();
		search_live = 1'b0;
		foreach (placed_column[i])
			placed_column[i] = '0;

		// Directed part. On the default eight by eight board a resume with no
		// search behind it acts as a restart and finds the first placement.
		add_step(STEP_REQUEST, 5'd0, 8, 1'b0, EIGHT_FIRST);
		add_step(STEP_REQUEST, 5'd1, 8, 1'b0, EIGHT_FIRST);
		add_step(STEP_REQUEST, 5'd0);
		add_step(STEP_REQUEST, 5'd0);
		// One queen: a single placement, then exhausted, and exhausted again
		// on a further resume.
		add_step(STEP_WRITE_SIZE, 5'd1);
		add_step(STEP_REQUEST, 5'd1, 1, 1'b0, 64'h0);
		add_step(STEP_REQUEST, 5'd0, 0, 1'b1);
		add_step(STEP_REQUEST, 5'd0, 0, 1'b1);
		// Size zero behaves as size one.
		add_step(STEP_WRITE_SIZE, 5'd0);
		add_step(STEP_REQUEST, 5'd0, 1, 1'b0, 64'h0);
		// Two and three have no placement at all.
		add_step(STEP_WRITE_SIZE, 5'd2);
		add_step(STEP_REQUEST, 5'd1, 0, 1'b1);
		add_step(STEP_WRITE_SIZE, 5'd3);
		add_step(STEP_REQUEST, 5'd1, 0, 1'b1);
		// Four has exactly two placements.
		add_step(STEP_WRITE_SIZE, 5'd4);
		add_step(STEP_REQUEST, 5'd1, 4, 1'b0, FOUR_FIRST);
		add_step(STEP_REQUEST, 5'd0, 4, 1'b0, FOUR_SECOND);
		add_step(STEP_REQUEST, 5'd0, 0, 1'b1);
		add_step(STEP_REQUEST, 5'd1, 4, 1'b0, FOUR_FIRST);
		// Rewriting the same size throws the search away, so a resume starts over.
		add_step(STEP_WRITE_SIZE, 5'd4);
		add_step(STEP_REQUEST, 5'd0, 4, 1'b0, FOUR_FIRST);
		// Largest board, then a size beyond it that saturates.
		add_step(STEP_WRITE_SIZE, 5'd16);
		add_step(STEP_REQUEST, 5'd1);
		add_step(STEP_WRITE_SIZE, 5'd31);
		add_step(STEP_REQUEST, 5'd0);
		add_step(STEP_REQUEST, 5'd0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (stimulus_plan[i])
			run_step(stimulus_plan[i]);
		directed_requests = requests_sent;

		// Random part: each phase picks a board size, starts a search and then
		// mostly resumes it, so small boards run through all their placements
		// into exhaustion. A few restarts are mixed in as noise.
		while (random_items < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 72)
				size = 5'($urandom_range(1, 8));
			else if (roll < 92)
				size = 5'($urandom_range(9, 13));
			else
				size = 5'd0;
			write_board_size(size);
			steady = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(3, 18);
			for (int unsigned i = 0; i < phase_len && random_items < RANDOM_ITEMS; i++) begin
				s.kind            = STEP_REQUEST;
				s.typed_rows      = 0;
				s.typed_exhausted = 1'b0;
				s.typed_columns   = '0;
				if (i == 0)
					s.value = 5'($urandom_range(0, 1));
				else
					s.value = 5'($urandom_range(0, 6) == 0);
				// Now and then the sender waits for the block to catch up fully.
				if ($urandom_range(0, 9) == 0)
					drain_results();
				send_request(s);
				random_items++;
			end
			steady = 1'b0;
		end

		// Back to the reset size so the last write is the default.
		write_board_size(5'(nq_pkg::BOARD_RESET));
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d search requests (%0d directed) over %0d board size writes.",
			requests_sent, directed_requests, size_writes);
		$display("Checked %0d full placements and %0d exhausted results in %0d cycles.",
			solutions_seen, exhausted_seen, cycle_count);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
